FILE: sv/pts_pkg.sv
// Package: token codes, scan modes, record types and scanning functions.
package pts_pkg;

  localparam int MaxTextLength = 80;
  localparam int RwCount = 35;
  localparam int FifoDepth = 4;

  localparam logic [5:0] TOK_IDENT   = 6'd0;
  localparam logic [5:0] TOK_INT     = 6'd1;
  localparam logic [5:0] TOK_REAL    = 6'd2;
  localparam logic [5:0] TOK_STRING  = 6'd3;
  localparam logic [5:0] TOK_EOF     = 6'd4;
  localparam logic [5:0] TOK_ERROR   = 6'd5;
  localparam logic [5:0] TOK_CARET   = 6'd6;
  localparam logic [5:0] TOK_COLON   = 6'd18;
  localparam logic [5:0] TOK_ASSIGN  = 6'd19;
  localparam logic [5:0] TOK_LT      = 6'd20;
  localparam logic [5:0] TOK_LE      = 6'd21;
  localparam logic [5:0] TOK_NE      = 6'd22;
  localparam logic [5:0] TOK_GT      = 6'd23;
  localparam logic [5:0] TOK_GE      = 6'd24;
  localparam logic [5:0] TOK_PERIOD  = 6'd25;
  localparam logic [5:0] TOK_DOTDOT  = 6'd26;
  localparam logic [5:0] TOK_RW_BASE = 6'd27;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_WORD       = 4'd1;
  localparam logic [3:0] M_INT        = 4'd2;
  localparam logic [3:0] M_INT_DOT    = 4'd3;
  localparam logic [3:0] M_FRAC       = 4'd4;
  localparam logic [3:0] M_EXP_START  = 4'd5;
  localparam logic [3:0] M_EXP_SIGN   = 4'd6;
  localparam logic [3:0] M_EXP_DIGITS = 4'd7;
  localparam logic [3:0] M_STRING     = 4'd8;
  localparam logic [3:0] M_COMMENT    = 4'd9;
  localparam logic [3:0] M_COLON      = 4'd10;
  localparam logic [3:0] M_LESS       = 4'd11;
  localparam logic [3:0] M_GREATER    = 4'd12;
  localparam logic [3:0] M_PERIOD     = 4'd13;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
  localparam logic [29:0] MANT_MAX  = 30'd999999999;

  localparam logic [71:0] RW_TXT [RwCount] = '{
    "do", "if", "in", "of", "or", "to",
    "and", "div", "end", "for", "mod", "nil", "not", "set", "var",
    "case", "else", "file", "goto", "then", "type", "with",
    "array", "begin", "const", "label", "until", "while",
    "downto", "packed", "record", "repeat",
    "program", "function", "procedure"
  };

  localparam logic [3:0] RW_LEN [RwCount] = '{
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd8, 4'd9
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } char_t;

  typedef struct packed {
    logic [5:0]        tok_kind;
    logic [30:0]       int_value;
    logic [29:0]       mantissa;
    logic signed [7:0] decimal_exponent;
    logic [63:0]       text;
    logic [6:0]        text_length;
    logic              overflow;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [8:0][7:0] w;
    logic [6:0]      cnt;
    logic [30:0]     ia;
    logic [29:0]     da;
    logic [7:0]      fd;
    logic [7:0]      ea;
    logic            en;
    logic            sat;
  } tok_st_t;

  typedef struct packed {
    tok_st_t    s;
    logic [3:0] mode;
    logic       e;
    token_t     r;
  } step_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0D;
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (is_letter(c) && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic tok_st_t begin_tok(tok_st_t s);
    tok_st_t t;
    t = s;
    t.cnt = '0;
    t.ia = '0;
    t.da = '0;
    t.fd = '0;
    t.ea = '0;
    t.en = 1'b0;
    t.sat = 1'b0;
    return t;
  endfunction

  function automatic tok_st_t append(tok_st_t s, logic [7:0] c, logic [6:0] lim);
    tok_st_t t;
    t = s;
    if (s.cnt < 7'd9) t.w[s.cnt[3:0]] = c;
    if (s.cnt < lim) t.cnt = s.cnt + 7'd1;
    else t.sat = 1'b1;
    return t;
  endfunction

  function automatic tok_st_t add_int(tok_st_t s, logic [3:0] d);
    tok_st_t t;
    logic [34:0] vi;
    logic [33:0] vd;
    t = s;
    vi = ({4'b0, s.ia} << 3) + ({4'b0, s.ia} << 1) + {31'b0, d};
    vd = ({4'b0, s.da} << 3) + ({4'b0, s.da} << 1) + {30'b0, d};
    if (vi > {4'b0, INT_MAX31}) begin
      t.ia = INT_MAX31;
      t.sat = 1'b1;
    end else begin
      t.ia = vi[30:0];
    end
    t.da = (vd > {4'b0, MANT_MAX}) ? MANT_MAX : vd[29:0];
    return t;
  endfunction

  function automatic tok_st_t add_frac(tok_st_t s, logic [3:0] d);
    tok_st_t t;
    logic [33:0] vd;
    t = s;
    vd = ({4'b0, s.da} << 3) + ({4'b0, s.da} << 1) + {30'b0, d};
    if (vd > {4'b0, MANT_MAX}) begin
      t.da = MANT_MAX;
      t.sat = 1'b1;
    end else begin
      t.da = vd[29:0];
    end
    if (s.fd != 8'hFF) t.fd = s.fd + 8'd1;
    else t.sat = 1'b1;
    return t;
  endfunction

  function automatic tok_st_t add_exp(tok_st_t s, logic [3:0] d);
    tok_st_t t;
    logic [11:0] v;
    t = s;
    v = ({4'b0, s.ea} << 3) + ({4'b0, s.ea} << 1) + {8'b0, d};
    if (v > 12'd255) begin
      t.ea = 8'hFF;
      t.sat = 1'b1;
    end else begin
      t.ea = v[7:0];
    end
    return t;
  endfunction

  function automatic tok_st_t to_real(tok_st_t s);
    tok_st_t t;
    t = s;
    if (s.ia > {1'b0, MANT_MAX}) t.sat = 1'b1;
    return t;
  endfunction

  function automatic token_t mk(tok_st_t s, logic [5:0] code, logic [30:0] ival,
                                logic [29:0] mant, logic signed [7:0] dexp);
    token_t r;
    r = '0;
    r.tok_kind = code;
    r.int_value = ival;
    r.mantissa = mant;
    r.decimal_exponent = dexp;
    for (int i = 0; i < 8; i++) begin
      if (7'(i) < s.cnt) r.text[8*i +: 8] = s.w[i];
    end
    r.text_length = s.cnt;
    r.overflow = s.sat;
    return r;
  endfunction

  function automatic logic [5:0] word_code(tok_st_t s);
    logic [5:0] code;
    logic       hit;
    code = TOK_IDENT;
    if (s.cnt >= 7'd2 && s.cnt <= 7'd9) begin
      for (int k = 0; k < RwCount; k++) begin
        hit = (RW_LEN[k] == s.cnt[3:0]);
        for (int i = 0; i < 9; i++) begin
          if (4'(i) < RW_LEN[k] &&
              s.w[i] != RW_TXT[k][8*(int'(RW_LEN[k]) - 1 - i) +: 8]) hit = 1'b0;
        end
        if (hit) code = TOK_RW_BASE + 6'(k);
      end
    end
    return code;
  endfunction

  // real emit: exponent = written exponent - fraction digits, clamped
  function automatic step_t emit_real(tok_st_t s);
    step_t o;
    logic signed [9:0] e;
    o = '0;
    o.s = s;
    e = (s.en ? -$signed({2'b0, s.ea}) : $signed({2'b0, s.ea})) - $signed({2'b0, s.fd});
    if (e > 10'sd127) begin
      e = 10'sd127;
      o.s.sat = 1'b1;
    end
    if (e < -10'sd128) begin
      e = -10'sd128;
      o.s.sat = 1'b1;
    end
    o.e = 1'b1;
    o.r = mk(o.s, TOK_REAL, '0, s.da, e[7:0]);
    return o;
  endfunction

  function automatic step_t finish(tok_st_t s, logic [3:0] mode, logic [6:0] lim);
    step_t o;
    o = '0;
    o.s = s;
    o.e = 1'b1;
    case (mode)
      M_WORD: o.r = mk(s, word_code(s), '0, '0, '0);
      M_INT: o.r = mk(s, TOK_INT, s.ia, '0, '0);
      M_INT_DOT: o = emit_real(append(to_real(s), ".", lim));
      M_FRAC, M_EXP_DIGITS: o = emit_real(s);
      M_EXP_START, M_EXP_SIGN, M_STRING: o.r = mk(s, TOK_ERROR, '0, '0, '0);
      M_COLON: o.r = mk(s, TOK_COLON, '0, '0, '0);
      M_LESS: o.r = mk(s, TOK_LT, '0, '0, '0);
      M_GREATER: o.r = mk(s, TOK_GT, '0, '0, '0);
      M_PERIOD: o.r = mk(s, TOK_PERIOD, '0, '0, '0);
      default: o.e = 1'b0;
    endcase
    o.mode = M_IDLE;
    return o;
  endfunction

  function automatic logic [5:0] single_code(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "^": k = 6'd0;
      "*": k = 6'd1;
      "(": k = 6'd2;
      ")": k = 6'd3;
      "-": k = 6'd4;
      "+": k = 6'd5;
      "=": k = 6'd6;
      "[": k = 6'd7;
      "]": k = 6'd8;
      ";": k = 6'd9;
      ",": k = 6'd10;
      "/": k = 6'd11;
      default: return TOK_ERROR;
    endcase
    return TOK_CARET + k;
  endfunction

  function automatic step_t start(tok_st_t s, logic [7:0] c, logic [6:0] lim);
    step_t o;
    o = '0;
    o.s = s;
    o.mode = M_IDLE;
    if (is_blank(c)) begin
      o.mode = M_IDLE;
    end else if (c == "{") begin
      o.mode = M_COMMENT;
    end else if (is_letter(c)) begin
      o.s = append(begin_tok(s), lower(c), lim);
      o.mode = M_WORD;
    end else begin
      o.s = append(begin_tok(s), c, lim);
      if (is_digit(c)) begin
        o.s = add_int(o.s, c[3:0]);
        o.mode = M_INT;
      end else if (c == 8'h27) begin
        o.mode = M_STRING;
      end else if (c == ":") begin
        o.mode = M_COLON;
      end else if (c == "<") begin
        o.mode = M_LESS;
      end else if (c == ">") begin
        o.mode = M_GREATER;
      end else if (c == ".") begin
        o.mode = M_PERIOD;
      end else begin
        o.e = 1'b1;
        o.r = mk(o.s, single_code(c), '0, '0, '0);
      end
    end
    return o;
  endfunction

endpackage

FILE: sv/pts_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface pts_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: sv/pascal_token_scanner_core.sv
// Pascal token scanner: one source byte per word in, tokens out.
//
// char_in carries one source byte per word (ch, end_of_input); token_out
// carries token words, each with its code, values, first eight characters,
// length, overflow flag and last, which marks the final token caused by an
// input word. A byte causes zero, one or two tokens.
// The scan step is combinational: the tokens of a byte accepted at one edge
// are written into the output queue at that same edge, so token_out.valid is
// high in the next cycle. Throughput is one byte per cycle while tokens
// drain at one per cycle; the four-entry output queue sets this, and
// char_in.ready drops while fewer than two entries are free. Bytes that
// yield two tokens thus slow the input.
// When the receiver stalls, the queue fills and char_in.ready falls; no
// token is lost. Synchronous reset empties the queue and returns the
// scanner to the idle state between tokens.
module pascal_token_scanner_core #(
  parameter int MAX_TEXT_LENGTH = pts_pkg::MaxTextLength
) (
  input logic clk,
  input logic rst,
  pts_chan_if.sink   char_in,
  pts_chan_if.source token_out
);
  import pts_pkg::*;

  localparam logic [6:0] LIMIT = 7'((MAX_TEXT_LENGTH < 127) ? MAX_TEXT_LENGTH : 127);
  localparam int PtrW = $clog2(FifoDepth);

  logic [3:0]  mode, mode_next;
  tok_st_t     ts, ts_next;
  token_t      fifo [FifoDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0]   count;

  char_t       cin;
  logic        acc, pop;
  logic [1:0]  n_res;
  token_t      r0, r1;

  assign cin = char_in.data;
  assign char_in.ready = count <= (PtrW+1)'(FifoDepth - 2);
  assign acc = char_in.valid && char_in.ready;
  assign token_out.valid = count != '0;
  assign token_out.data = fifo[rp];
  assign pop = token_out.valid && token_out.ready;

  always_comb begin
    step_t   f1, f2;
    tok_st_t s;
    logic [7:0] c;
    logic    ea, eb, d;
    token_t  ra, rb;
    c = cin.ch;
    d = is_digit(c);
    s = ts;
    mode_next = mode;
    ea = 1'b0;
    eb = 1'b0;
    ra = '0;
    rb = '0;
    f1 = finish(ts, mode, LIMIT);
    f2 = start(f1.s, c, LIMIT);
    if (cin.end_of_input) begin
      s = begin_tok(f1.s);
      ea = f1.e;
      ra = f1.r;
      eb = 1'b1;
      rb = mk(s, TOK_EOF, '0, '0, '0);
      mode_next = M_IDLE;
    end else begin
      case (mode)
        M_COMMENT: begin
          if (c == "}") mode_next = M_IDLE;
        end
        M_STRING: begin
          s = append(ts, c, LIMIT);
          if (c == 8'h27) begin
            ea = 1'b1;
            ra = mk(s, TOK_STRING, '0, '0, '0);
            mode_next = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_letter(c) || d) s = append(ts, lower(c), LIMIT);
          else mode_next = M_IDLE;
        end
        M_INT: begin
          if (d) begin
            s = add_int(append(ts, c, LIMIT), c[3:0]);
          end else if (c == ".") begin
            mode_next = M_INT_DOT;
          end else if (c == "e" || c == "E") begin
            s = append(to_real(ts), c, LIMIT);
            mode_next = M_EXP_START;
          end else begin
            mode_next = M_IDLE;
          end
        end
        M_INT_DOT: begin
          if (c == ".") begin
            ea = 1'b1;
            ra = mk(ts, TOK_INT, ts.ia, '0, '0);
            s = append(append(begin_tok(ts), ".", LIMIT), ".", LIMIT);
            eb = 1'b1;
            rb = mk(s, TOK_DOTDOT, '0, '0, '0);
            mode_next = M_IDLE;
          end else if (d) begin
            s = add_frac(append(append(to_real(ts), ".", LIMIT), c, LIMIT), c[3:0]);
            mode_next = M_FRAC;
          end else if (c == "e" || c == "E") begin
            s = append(append(to_real(ts), ".", LIMIT), c, LIMIT);
            mode_next = M_EXP_START;
          end else begin
            mode_next = M_IDLE;
          end
        end
        M_FRAC: begin
          if (d) begin
            s = add_frac(append(ts, c, LIMIT), c[3:0]);
          end else if (c == "e" || c == "E") begin
            s = append(ts, c, LIMIT);
            mode_next = M_EXP_START;
          end else begin
            mode_next = M_IDLE;
          end
        end
        M_EXP_START, M_EXP_SIGN, M_EXP_DIGITS: begin
          if (mode == M_EXP_START && (c == "+" || c == "-")) begin
            s = append(ts, c, LIMIT);
            s.en = (c == "-");
            mode_next = M_EXP_SIGN;
          end else if (d) begin
            s = add_exp(append(ts, c, LIMIT), c[3:0]);
            mode_next = M_EXP_DIGITS;
          end else begin
            mode_next = M_IDLE;
          end
        end
        M_COLON, M_LESS, M_GREATER, M_PERIOD: begin
          mode_next = M_IDLE;
          if ((mode == M_COLON && c == "=") || (mode == M_LESS && c == "=")
              || (mode == M_LESS && c == ">") || (mode == M_GREATER && c == "=")
              || (mode == M_PERIOD && c == ".")) begin
            s = append(ts, c, LIMIT);
            ea = 1'b1;
            case (mode)
              M_COLON: ra = mk(s, TOK_ASSIGN, '0, '0, '0);
              M_LESS: ra = mk(s, (c == ">") ? TOK_NE : TOK_LE, '0, '0, '0);
              M_GREATER: ra = mk(s, TOK_GE, '0, '0, '0);
              default: ra = mk(s, TOK_DOTDOT, '0, '0, '0);
            endcase
          end
        end
        default: begin
          s = f2.s;
          mode_next = f2.mode;
          ea = f2.e;
          ra = f2.r;
        end
      endcase
      // token broken by this byte: emit it, then rescan the byte
      if (mode != M_IDLE && mode != M_COMMENT && mode != M_STRING && !ea
          && mode_next == M_IDLE) begin
        s = f2.s;
        mode_next = f2.mode;
        ea = f1.e;
        ra = f1.r;
        eb = f2.e;
        rb = f2.r;
      end
    end
    ts_next = s;
    r0 = ea ? ra : rb;
    r1 = rb;
    n_res = {1'b0, ea} + {1'b0, eb};
    if (n_res == 2'd2) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      ts.cnt <= '0;
      ts.ia <= '0;
      ts.da <= '0;
      ts.fd <= '0;
      ts.ea <= '0;
      ts.en <= 1'b0;
      ts.sat <= 1'b0;
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (acc) begin
        mode <= mode_next;
        ts <= ts_next;
        wp <= wp + n_res[PtrW-1:0];
      end
      if (pop) rp <= rp + 1'b1;
      count <= count + (acc ? (PtrW+1)'(n_res) : '0) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n_res != 2'd0) fifo[wp] <= r0;
    if (acc && n_res == 2'd2) fifo[wp + 1'b1] <= r1;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW+1)'(FifoDepth)) else $error("token queue overrun");
  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    acc && cin.end_of_input |=> mode == M_IDLE) else $error("not idle after eof");
  a_eof_tokens: assert property (@(posedge clk) disable iff (rst)
    acc && cin.end_of_input |-> n_res != 2'd0) else $error("eof gave no token");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> mode == M_IDLE && count == '0) else $error("reset state");
`endif

endmodule

FILE: tb/tb_pts.sv
`timescale 1ns / 100ps
// Testbench for pascal_token_scanner_core: scripted and random text against a scan model.
module tb;
  import pts_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int TextLimit = (MaxTextLength < 127) ? MaxTextLength : 127;

  logic clk;
  logic rst;

  pts_chan_if #(.payload_t(char_t))  char_in();
  pts_chan_if #(.payload_t(token_t)) token_out();

  pascal_token_scanner_core dut (
    .clk(clk),
    .rst(rst),
    .char_in(char_in),
    .token_out(token_out)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scanner model state
  logic [3:0]      scan_state;
  logic [8:0][7:0] tok_chars;
  int unsigned     tok_len;
  int unsigned     int_acc;
  int unsigned     mant_acc;
  int unsigned     frac_cnt;
  int unsigned     exp_acc;
  logic            exp_neg;
  logic            tok_sat;

  token_t expected_tokens[$];
  char_t  pending_chars[$];
  int     error_count;
  int     idle_cycles;
  bit     hold_send;
  bit     stim_done;

  function automatic bit letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  task automatic clear_token();
    tok_len = 0;
    int_acc = 0;
    mant_acc = 0;
    frac_cnt = 0;
    exp_acc = 0;
    exp_neg = 1'b0;
    tok_sat = 1'b0;
  endtask

  task automatic keep_char(logic [7:0] c);
    if (tok_len < 9) tok_chars[tok_len] = c;
    if (tok_len < TextLimit) tok_len++;
    else tok_sat = 1'b1;
  endtask

  task automatic push_token(logic [5:0] code, int unsigned ival, int unsigned mant,
                            int dexp);
    token_t t;
    t = '0;
    t.tok_kind = code;
    t.int_value = ival[30:0];
    t.mantissa = mant[29:0];
    t.decimal_exponent = dexp[7:0];
    for (int i = 0; i < 8; i++) if (i < tok_len) t.text[8*i +: 8] = tok_chars[i];
    t.text_length = tok_len[6:0];
    t.overflow = tok_sat;
    expected_tokens.push_back(t);
  endtask

  task automatic int_digit(int unsigned d);
    if (int_acc > (32'h7FFF_FFFF - d) / 10) begin
      int_acc = 32'h7FFF_FFFF;
      tok_sat = 1'b1;
    end else int_acc = int_acc * 10 + d;
    if (mant_acc > (999999999 - d) / 10) mant_acc = 999999999;
    else mant_acc = mant_acc * 10 + d;
  endtask

  task automatic frac_digit(int unsigned d);
    if (mant_acc > (999999999 - d) / 10) begin
      mant_acc = 999999999;
      tok_sat = 1'b1;
    end else mant_acc = mant_acc * 10 + d;
    if (frac_cnt < 255) frac_cnt++;
    else tok_sat = 1'b1;
  endtask

  task automatic exp_digit(int unsigned d);
    if (exp_acc > (255 - d) / 10) begin
      exp_acc = 255;
      tok_sat = 1'b1;
    end else exp_acc = exp_acc * 10 + d;
  endtask

  task automatic check_mant_fit();
    if (int_acc > 999999999) tok_sat = 1'b1;
  endtask

  task automatic push_real();
    int e;
    e = exp_neg ? -int'(exp_acc) : int'(exp_acc);
    e -= int'(frac_cnt);
    if (e > 127) begin
      e = 127;
      tok_sat = 1'b1;
    end
    if (e < -128) begin
      e = -128;
      tok_sat = 1'b1;
    end
    push_token(TOK_REAL, 0, mant_acc, e);
  endtask

  task automatic push_word();
    logic [5:0] code;
    bit         hit;
    int         n;
    code = TOK_IDENT;
    if (tok_len >= 2 && tok_len <= 9) begin
      for (int k = 0; k < RwCount; k++) begin
        n = RW_LEN[k];
        if (n == tok_len) begin
          hit = 1'b1;
          for (int i = 0; i < n; i++)
            if (tok_chars[i] != RW_TXT[k][8*(n-1-i) +: 8]) hit = 1'b0;
          if (hit) code = TOK_RW_BASE + 6'(k);
        end
      end
    end
    push_token(code, 0, 0, 0);
  endtask

  task automatic flush_token();
    case (scan_state)
      M_WORD: push_word();
      M_INT: push_token(TOK_INT, int_acc, 0, 0);
      M_INT_DOT: begin
        check_mant_fit();
        keep_char(".");
        push_real();
      end
      M_FRAC, M_EXP_DIGITS: push_real();
      M_EXP_START, M_EXP_SIGN, M_STRING: push_token(TOK_ERROR, 0, 0, 0);
      M_COLON: push_token(TOK_COLON, 0, 0, 0);
      M_LESS: push_token(TOK_LT, 0, 0, 0);
      M_GREATER: push_token(TOK_GT, 0, 0, 0);
      M_PERIOD: push_token(TOK_PERIOD, 0, 0, 0);
      default: ;
    endcase
    scan_state = M_IDLE;
  endtask

  task automatic fresh_char(logic [7:0] c);
    logic [5:0] code;
    scan_state = M_IDLE;
    if (c == 8'h20 || c == 8'h0A || c == 8'h09 || c == 8'h0D) return;
    if (c == "{") begin
      scan_state = M_COMMENT;
      return;
    end
    clear_token();
    if (letter_c(c)) begin
      keep_char(fold_case(c));
      scan_state = M_WORD;
      return;
    end
    keep_char(c);
    if (digit_c(c)) begin
      int_digit(c - "0");
      scan_state = M_INT;
    end else if (c == 8'h27) scan_state = M_STRING;
    else if (c == ":") scan_state = M_COLON;
    else if (c == "<") scan_state = M_LESS;
    else if (c == ">") scan_state = M_GREATER;
    else if (c == ".") scan_state = M_PERIOD;
    else begin
      case (c)
        "^": code = TOK_CARET;
        "*": code = TOK_CARET + 6'd1;
        "(": code = TOK_CARET + 6'd2;
        ")": code = TOK_CARET + 6'd3;
        "-": code = TOK_CARET + 6'd4;
        "+": code = TOK_CARET + 6'd5;
        "=": code = TOK_CARET + 6'd6;
        "[": code = TOK_CARET + 6'd7;
        "]": code = TOK_CARET + 6'd8;
        ";": code = TOK_CARET + 6'd9;
        ",": code = TOK_CARET + 6'd10;
        "/": code = TOK_CARET + 6'd11;
        default: code = TOK_ERROR;
      endcase
      push_token(code, 0, 0, 0);
    end
  endtask

  task automatic pair_char(logic [7:0] c, logic [7:0] second, logic [5:0] code);
    if (c == second) begin
      keep_char(c);
      push_token(code, 0, 0, 0);
      scan_state = M_IDLE;
    end else begin
      flush_token();
      fresh_char(c);
    end
  endtask

  task automatic scan_char(char_t w);
    logic [7:0] c;
    bit         d;
    int         before_n;
    c = w.ch;
    d = digit_c(c);
    before_n = expected_tokens.size();
    if (w.end_of_input) begin
      flush_token();
      clear_token();
      push_token(TOK_EOF, 0, 0, 0);
    end else begin
      case (scan_state)
        M_COMMENT: if (c == "}") scan_state = M_IDLE;
        M_STRING: begin
          keep_char(c);
          if (c == 8'h27) begin
            push_token(TOK_STRING, 0, 0, 0);
            scan_state = M_IDLE;
          end
        end
        M_WORD: begin
          if (letter_c(c) || d) keep_char(fold_case(c));
          else begin
            flush_token();
            fresh_char(c);
          end
        end
        M_INT: begin
          if (d) begin
            keep_char(c);
            int_digit(c - "0");
          end else if (c == ".") scan_state = M_INT_DOT;
          else if (c == "e" || c == "E") begin
            check_mant_fit();
            keep_char(c);
            scan_state = M_EXP_START;
          end else begin
            flush_token();
            fresh_char(c);
          end
        end
        M_INT_DOT: begin
          if (c == ".") begin
            push_token(TOK_INT, int_acc, 0, 0);
            clear_token();
            keep_char(".");
            keep_char(".");
            push_token(TOK_DOTDOT, 0, 0, 0);
            scan_state = M_IDLE;
          end else if (d) begin
            check_mant_fit();
            keep_char(".");
            keep_char(c);
            frac_digit(c - "0");
            scan_state = M_FRAC;
          end else if (c == "e" || c == "E") begin
            check_mant_fit();
            keep_char(".");
            keep_char(c);
            scan_state = M_EXP_START;
          end else begin
            flush_token();
            fresh_char(c);
          end
        end
        M_FRAC: begin
          if (d) begin
            keep_char(c);
            frac_digit(c - "0");
          end else if (c == "e" || c == "E") begin
            keep_char(c);
            scan_state = M_EXP_START;
          end else begin
            flush_token();
            fresh_char(c);
          end
        end
        M_EXP_START, M_EXP_SIGN, M_EXP_DIGITS: begin
          if (scan_state == M_EXP_START && (c == "+" || c == "-")) begin
            keep_char(c);
            exp_neg = (c == "-");
            scan_state = M_EXP_SIGN;
          end else if (d) begin
            keep_char(c);
            exp_digit(c - "0");
            scan_state = M_EXP_DIGITS;
          end else begin
            flush_token();
            fresh_char(c);
          end
        end
        M_COLON: pair_char(c, "=", TOK_ASSIGN);
        M_LESS: pair_char(c, (c == ">") ? 8'h3E : 8'h3D, (c == ">") ? TOK_NE : TOK_LE);
        M_GREATER: pair_char(c, "=", TOK_GE);
        M_PERIOD: pair_char(c, ".", TOK_DOTDOT);
        default: fresh_char(c);
      endcase
    end
    if (expected_tokens.size() > before_n)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // stimulus helpers
  task automatic add_char(logic [7:0] c);
    char_t w;
    w.ch = c;
    w.end_of_input = 1'b0;
    pending_chars.push_back(w);
  endtask

  task automatic add_eof();
    char_t w;
    w.ch = 8'($urandom);
    w.end_of_input = 1'b1;
    pending_chars.push_back(w);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_word();
    string s;
    int    n;
    byte   c;
    n = $urandom_range(1, 12);
    s = "";
    for (int i = 0; i < n; i++) begin
      c = (i > 0 && $urandom_range(0, 4) == 0) ? 8'("0" + $urandom_range(0, 9)) :
          8'("a" + $urandom_range(0, 25));
      if ($urandom_range(0, 3) == 0 && c >= "a") c = c - 32;
      s = {s, string'(c)};
    end
    return s;
  endfunction

  function automatic string rand_piece();
    int         k;
    int         n;
    logic [7:0] b;
    string      s;
    k = $urandom_range(0, 15);
    case (k)
      0, 1: begin
        n = $urandom_range(0, RwCount - 1);
        s = "";
        for (int i = 0; i < RW_LEN[n]; i++)
          s = {s, string'(RW_TXT[n][8*(RW_LEN[n]-1-i) +: 8])};
      end
      2, 3: s = rand_word();
      4: s = rand_digits($urandom_range(1, ($urandom_range(0, 5) == 0) ? 14 : 5));
      5: s = {rand_digits($urandom_range(1, 11)), ".", rand_digits($urandom_range(0, 11))};
      6: begin
        s = {rand_digits($urandom_range(1, 4)), ".", rand_digits($urandom_range(1, 4)),
             ($urandom_range(0, 1) ? "e" : "E")};
        case ($urandom_range(0, 2))
          0: s = {s, "+"};
          1: s = {s, "-"};
          default: ;
        endcase
        s = {s, rand_digits($urandom_range(0, 4))};
      end
      7: s = {rand_digits($urandom_range(1, 3)), "..", rand_digits($urandom_range(1, 3))};
      8: begin
        s = "'";
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == 8'h27) b = "x";
          s = {s, string'(b)};
        end
        s = {s, "'"};
      end
      9: begin
        case ($urandom_range(0, 7))
          0: s = ":=";
          1: s = "<=";
          2: s = "<>";
          3: s = ">=";
          4: s = "..";
          5: s = ":";
          6: s = "<";
          default: s = ">";
        endcase
      end
      10: s = string'(8'($urandom_range(0, 255)));
      11: s = {"{", rand_word(), " ", rand_digits(2), "}"};
      12: s = ".";
      default: begin
        case ($urandom_range(0, 11))
          0: s = "^"; 1: s = "*"; 2: s = "("; 3: s = ")"; 4: s = "-"; 5: s = "+";
          6: s = "="; 7: s = "["; 8: s = "]"; 9: s = ";"; 10: s = ","; default: s = "/";
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic string rand_blank();
    case ($urandom_range(0, 5))
      0: return "\n";
      1: return "\t";
      2: return "\r";
      3: return "";
      default: return " ";
    endcase
  endfunction

  // word taken at the last rising edge
  bit in_fire;
  always @(posedge clk) in_fire <= char_in.valid && char_in.ready;

  // driver
  int send_wait;
  always @(negedge clk) begin
    if (rst) begin
      char_in.valid <= 1'b0;
      char_in.data <= '0;
      send_wait <= $urandom_range(0, 17);
    end else if (char_in.valid && !in_fire) begin
    end else if (send_wait > 0) begin
      char_in.valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (pending_chars.size() > 0 && !(hold_send && expected_tokens.size() > 0)) begin
      char_in.valid <= 1'b1;
      char_in.data <= pending_chars.pop_front();
      send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17) *
                   ($urandom_range(0, 3) == 0);
    end else begin
      char_in.valid <= 1'b0;
    end
  end

  // receiver stalls
  int recv_wait;
  always @(negedge clk) begin
    if (rst) begin
      token_out.ready <= 1'b0;
      recv_wait <= 0;
    end else if (recv_wait > 0) begin
      token_out.ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      token_out.ready <= 1'b1;
      if (token_out.valid && token_out.ready)
        recv_wait <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17) *
                     ($urandom_range(0, 3) == 0);
    end
  end

  // monitor and checker
  token_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (char_in.valid && char_in.ready) scan_char(char_in.data);
      if (token_out.valid && token_out.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token", 64'(token_out.data.tok_kind), 0);
        end else begin
          want = expected_tokens.pop_front();
          if (token_out.data.tok_kind != want.tok_kind)
            report_mismatch("tok_kind", 64'(token_out.data.tok_kind),
                            64'(want.tok_kind));
          if (token_out.data.int_value != want.int_value)
            report_mismatch("int_value", 64'(token_out.data.int_value), 64'(want.int_value));
          if (token_out.data.mantissa != want.mantissa)
            report_mismatch("mantissa", 64'(token_out.data.mantissa), 64'(want.mantissa));
          if (token_out.data.decimal_exponent != want.decimal_exponent)
            report_mismatch("decimal_exponent", 64'(token_out.data.decimal_exponent),
                            64'(want.decimal_exponent));
          if (token_out.data.text != want.text)
            report_mismatch("text", token_out.data.text, want.text);
          if (token_out.data.text_length != want.text_length)
            report_mismatch("text_length", 64'(token_out.data.text_length),
                            64'(want.text_length));
          if (token_out.data.overflow != want.overflow)
            report_mismatch("overflow", 64'(token_out.data.overflow), 64'(want.overflow));
          if (token_out.data.last != want.last)
            report_mismatch("last", 64'(token_out.data.last), 64'(want.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (char_in.valid && char_in.ready) || (token_out.valid && token_out.ready) ||
        (stim_done && expected_tokens.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      $display("pascal_token_scanner_core regression: fail");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    error_count = 0;
    hold_send = 1'b0;
    stim_done = 1'b0;
    scan_state = M_IDLE;
    tok_chars = '0;
    clear_token();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: specials, reserved words, number corners, errors
    add_text("procedure Function x1 := a<>b<=c>=d<e>f:g ^*()-+=[];,/ ");
    add_text("12..3 12. 7.5e-3 1e+ 2147483648 99999999999 1.5e999 ");
    add_text("{c} } 'it''s' @");
    add_char(8'h00);
    add_char(8'hFF);
    add_text(" abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ");
    add_text("abcdefghijklmnopqrstuvwxyz0123");
    add_text(" 'open");
    add_eof();
    add_text("{x");
    add_eof();
    add_text("5.");
    add_eof();
    add_text("0.");
    add_text(rand_digits(260));
    add_text("e9");
    add_eof();
    add_text("1e");
    add_text(rand_digits(4));
    add_text("<");
    add_eof();

    while (pending_chars.size() < 1800) begin
      if ($urandom_range(0, 9) == 0) add_char(8'($urandom_range(0, 255)));
      else add_text({rand_piece(), rand_blank()});
      if ($urandom_range(0, 80) == 0) add_eof();
    end
    add_eof();

    // hold the sender until all tokens have drained
    wait (pending_chars.size() <= 900 && expected_tokens.size() > 0);
    hold_send = 1'b1;
    wait (expected_tokens.size() == 0);
    hold_send = 1'b0;

    wait (pending_chars.size() == 0);
    @(posedge clk);
    wait (!char_in.valid);
    stim_done = 1'b1;
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("pascal_token_scanner_core regression: pass");
    else $display("pascal_token_scanner_core regression: fail");
    $finish;
  end
endmodule

FILE: filelist.f
sv/pts_pkg.sv
sv/pts_chan_if.sv
sv/pascal_token_scanner_core.sv
tb/tb_pts.sv
